>>> rtl/binary_to_seven_segment_display_unit_macros.svh
// Assertion macros for the RTL files.
`ifndef BINARY_TO_SEVEN_SEGMENT_DISPLAY_UNIT_MACROS_SVH
`define BINARY_TO_SEVEN_SEGMENT_DISPLAY_UNIT_MACROS_SVH

`ifndef SYNTH

// Checked on clk_i, off while rst_ni is low.
`define B7S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on clk_i at every edge, reset included.
`define B7S_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define B7S_ASSERT(lbl, prop, msg)
`define B7S_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/b7s_pkg.sv
package b7s_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned NumPlaces  = 5;
  localparam int unsigned OutWidth   = ((NumPlaces * SegWidth + NumPlaces + 7) / 8) * 8;

  // floor(x / d) == (x * M) >> S, exact for every 16-bit x
  localparam logic [16:0] RecipTen        = 17'd52429;
  localparam logic [16:0] RecipHundred    = 17'd83887;
  localparam logic [16:0] RecipThousand   = 17'd67109;
  localparam logic [16:0] RecipTenThousand = 17'd107375;

  localparam logic [SegWidth-1:0] SegBlank = 8'h00;

  typedef struct packed {
    logic [12:0] q1;  // value / 10
    logic [9:0]  q2;  // value / 100
    logic [6:0]  q3;  // value / 1000
    logic [2:0]  q4;  // value / 10000
  } quot_t;

  // a - 10*q, low four bits only; exact when the true result is a digit
  function automatic logic [DigitWidth-1:0] mod10_digit(logic [DigitWidth-1:0] a,
                                                         logic [DigitWidth-1:0] q);
    logic [DigitWidth-1:0] ten_q;
    ten_q = {q[0], 3'b000} + {q[2:0], 1'b0};
    return a - ten_q;
  endfunction

  function automatic logic [SegWidth-1:0] seg_encode(logic [DigitWidth-1:0] d);
    logic [SegWidth-1:0] s;
    case (d)
      4'd0: s = 8'hFC;
      4'd1: s = 8'h60;
      4'd2: s = 8'hDB;
      4'd3: s = 8'hF3;
      4'd4: s = 8'h67;
      4'd5: s = 8'hB7;
      4'd6: s = 8'hBF;
      4'd7: s = 8'hE0;
      4'd8: s = 8'hFF;
      4'd9: s = 8'hF7;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/binary_to_seven_segment_display_unit.sv
// Pipeline: constant-reciprocal multipliers feed the quotient register; the digit
// fix-up and segment lookup feed the result register.
// Throughput: one beat per cycle while m_axis_tready does not stall the output.
// Reset: rst_ni clears both valid flags; no beat is held after reset.
`include "binary_to_seven_segment_display_unit_macros.svh"

module binary_to_seven_segment_display_unit import b7s_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // value[15:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutWidth-1:0] m_axis_tdata    // seg_ones[7:0], seg_tens[15:8],
                                              // seg_hundreds[23:16], seg_thousands[31:24],
                                              // seg_ten_thousands[39:32],
                                              // place_written[44:40], zero[47:45]
);

  logic                  s1_valid_q, s1_valid_d;
  logic [ValueWidth-1:0] value_q;
  quot_t                 quot_q;
  quot_t                 quot_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutWidth-1:0]   out_data_q, out_data_d;

  logic s1_ready;
  logic out_ready;
  logic s_accept;
  logic s1_move;

  logic [DigitWidth-1:0] dig [NumPlaces];
  logic [NumPlaces-1:0]  written;
  logic [SegWidth-1:0]   seg [NumPlaces];

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign s_accept      = s_axis_tvalid && s1_ready;
  assign s1_move       = s1_valid_q && out_ready;

  b7s_split u_split (
    .value_i (s_axis_tdata),
    .quot_o  (quot_d)
  );

  always_comb begin
    dig[0] = mod10_digit(value_q[3:0], quot_q.q1[3:0]);
    dig[1] = mod10_digit(quot_q.q1[3:0], quot_q.q2[3:0]);
    dig[2] = mod10_digit(quot_q.q2[3:0], quot_q.q3[3:0]);
    dig[3] = mod10_digit(quot_q.q3[3:0], {1'b0, quot_q.q4});
    dig[4] = {1'b0, quot_q.q4};

    written[0] = 1'b1;
    written[1] = quot_q.q1 != '0;
    written[2] = quot_q.q2 != '0;
    written[3] = quot_q.q3 != '0;
    written[4] = quot_q.q4 != '0;

    for (int k = 0; k < NumPlaces; k++) begin
      seg[k] = written[k] ? seg_encode(dig[k]) : SegBlank;
    end

    out_data_d = {3'b000, written, seg[4], seg[3], seg[2], seg[1], seg[0]};
  end

  always_comb begin
    s1_valid_d  = s1_ready ? s_axis_tvalid : s1_valid_q;
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      value_q <= s_axis_tdata;
      quot_q  <= quot_d;
    end
    if (s1_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ones place is always lit, higher places fill from the bottom up
  `B7S_ASSERT(a_ones_written, m_axis_tvalid |-> m_axis_tdata[40], "ones place not written")
  `B7S_ASSERT(a_place_thermo, m_axis_tvalid |-> (((m_axis_tdata[44:40] + 5'd1) & m_axis_tdata[44:40]) == 5'd0), "place mask has a gap")
  `B7S_ASSERT(a_blank_tens, (m_axis_tvalid && !m_axis_tdata[41]) |-> (m_axis_tdata[15:8] == SegBlank), "unwritten tens not blank")
  `B7S_ASSERT(a_s1_hold, (s1_valid_q && !out_ready) |=> (s1_valid_q && $stable(value_q)), "stage one lost a stalled beat")
  `B7S_ASSERT(a_s1_fill, s_accept |=> s1_valid_q, "accepted beat not captured")

endmodule

>>> rtl/b7s_split.sv
module b7s_split import b7s_pkg::*; (
  input  logic [ValueWidth-1:0] value_i,
  output quot_t                 quot_o
);

  logic [31:0] prod_ten;
  logic [32:0] prod_hundred;
  logic [32:0] prod_thousand;
  logic [32:0] prod_ten_thousand;

  assign prod_ten          = 32'(value_i * RecipTen[15:0]);
  assign prod_hundred      = 33'({17'd0, value_i} * {16'd0, RecipHundred});
  assign prod_thousand     = 33'({17'd0, value_i} * {16'd0, RecipThousand});
  assign prod_ten_thousand = 33'({17'd0, value_i} * {16'd0, RecipTenThousand});

  assign quot_o.q1 = prod_ten[31:19];
  assign quot_o.q2 = prod_hundred[32:23];
  assign quot_o.q3 = prod_thousand[32:26];
  assign quot_o.q4 = prod_ten_thousand[32:30];

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench import b7s_pkg::*;;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PrintLimit  = 40;
  localparam int unsigned DrainCycles = 6;

  localparam logic [SegWidth-1:0] DigitSegments [10] = '{
    8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE0, 8'hFF, 8'hF7
  };

  typedef struct packed {
    logic [OutWidth-NumPlaces*SegWidth-NumPlaces-1:0] pad;
    logic [NumPlaces-1:0]                             place_written;
    logic [NumPlaces-1:0][SegWidth-1:0]               seg;
  } display_t;

  string place_name [NumPlaces] = '{"ones", "tens", "hundreds", "thousands",
                                    "ten_thousands"};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;  // value[15:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;        // seg_ones .. seg_ten_thousands, place_written

  display_t    pending_displays [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned values_sent   = 0;
  int unsigned beats_checked = 0;
  logic [NumPlaces-1:0] places_seen = '0;

  binary_to_seven_segment_display_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_displays.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic display_t predict_display(logic [15:0] value);
    display_t    d;
    int unsigned weight;
    d      = '0;
    weight = 1;
    for (int k = 0; k < NumPlaces; k++) begin
      if (k == 0 || value >= weight) begin
        d.seg[k]           = DigitSegments[(value / weight) % 10];
        d.place_written[k] = 1'b1;
      end
      weight = weight * 10;
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    display_t got;
    display_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = display_t'(m_axis_tdata);
      if (pending_displays.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, 0);
      end else begin
        want = pending_displays.pop_front();
        beats_checked++;
        places_seen |= got.place_written;
        for (int k = 0; k < NumPlaces; k++) begin
          if (got.seg[k] !== want.seg[k]) begin
            report_mismatch({"seg_", place_name[k]}, got.seg[k], want.seg[k]);
          end
        end
        if (got.place_written !== want.place_written) begin
          report_mismatch("place_written", got.place_written, want.place_written);
        end
        if (got.pad !== want.pad) begin
          report_mismatch("padding", got.pad, want.pad);
        end
      end
    end
  end

  task automatic send_value(logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_displays.push_back(predict_display(value));
    values_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk_i);
  endtask

  // place thresholds and edges of the range
  task automatic test_directed_values();
    logic [15:0] values [23] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                                 16'd1000, 16'd9999, 16'd10000, 16'd65535, 16'd12345,
                                 16'd56789, 16'd45678, 16'h5555, 16'hAAAA,
                                 16'h8000, 16'h7FFF, 16'd50505, 16'd9009, 16'd101,
                                 16'd23456, 16'd34567};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (20) send_value(16'($urandom));
    wait_for_results();
    repeat (20) send_value(16'($urandom));
  endtask

  task automatic test_random_values(int unsigned count, int unsigned send_pct,
                                    int unsigned recv_pct);
    int unsigned thresholds [4] = '{10, 100, 1000, 10000};
    logic [15:0] value;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      case ($urandom_range(3))
        0, 1: value = 16'($urandom);
        2:    value = 16'(thresholds[$urandom_range(3)] + $urandom_range(3) - 2);
        default: value = 16'($urandom_range(999));
      endcase
      send_value(value);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_drain_pause();
    test_random_values(580, 29, 50);
    test_random_values(580, 50, 29);
    test_random_values(580, 0, 0);

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d counts, checked %0d result beats; places lit mask 0b%05b",
             values_sent, beats_checked, places_seen);
    $display("Covered place thresholds, full range and three flow-control mixes");
    if (mismatches == 0 && pending_displays.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
